/* rtl/core/cai_pkg.sv */
// Package for the CoM admittance integrator: item structs, op codes,
// register map and fixed-point constants. No dependencies.
package cai_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DT_FRAC   = 16;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned DT_RESET  = 66;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_SET_POS = 2'd1,
    OP_SET_VEL = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_GAIN_X    = 2'd0,
    REG_GAIN_Y    = 2'd1,
    REG_GAIN_Z    = 2'd2,
    REG_TIME_STEP = 2'd3
  } reg_e;

  typedef struct packed {
    op_e                      op;
    logic [1:0]               axis;
    logic signed [DATA_W-1:0] zmp_meas;
    logic signed [DATA_W-1:0] zmp_target;
    logic signed [DATA_W-1:0] accel_target;
    logic signed [DATA_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               out_axis;
    logic                     valid_res;
    logic signed [DATA_W-1:0] accel_ref;
    logic signed [DATA_W-1:0] pos_ref;
    logic signed [DATA_W-1:0] vel_ref;
  } out_item_t;

endpackage

/* rtl/core/com_admittance_integrator_top.sv */
// CoM admittance integrator: per-axis ZMP admittance and double integrator.
// Depends on cai_pkg. Shares one radix-16 digit-serial multiplier.
//
// Usage:
//   Input beats (in_valid_i/in_ready_o, in_data_i) carry step, set position,
//   set velocity or init items; each gives one output beat
//   (out_valid_o/out_ready_i, out_data_o).
//   Gains and time step sit on an APB port (byte addr 4*index), pready
//   always high; write them only while the block is idle.
//   A step item runs through the shared multiplier, one 4-bit digit per
//   cycle: 8 digits for gain times ZMP error, then 4 each for vel*dt,
//   accel*dt and (accel*dt)*dt, with rounding and summing states between.
//   No new item is taken until the result is in the output register.
//   Set and init items go straight from idle to the output state.
//   Reset clears state, gains to 0, time step to 66, block not initialized.
//   A stalled receiver holds the output register; one more item is accepted
//   and worked off, then the block waits with its result until the
//   register frees.
module com_admittance_integrator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cai_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cai_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cai_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_G_MUL  = 4'd1;
  localparam logic [3:0] S_G_RND  = 4'd2;
  localparam logic [3:0] S_ACCEL  = 4'd3;
  localparam logic [3:0] S_V_MUL  = 4'd4;
  localparam logic [3:0] S_V_RND  = 4'd5;
  localparam logic [3:0] S_A_MUL  = 4'd6;
  localparam logic [3:0] S_A_RND  = 4'd7;
  localparam logic [3:0] S_A2_MUL = 4'd8;
  localparam logic [3:0] S_A2_RND = 4'd9;
  localparam logic [3:0] S_SUM    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  localparam int unsigned ACC_W = 66;
  localparam int unsigned T_W   = ACC_W - cai_pkg::FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v[50:31] == {20{v[50]}}) begin
      r = v[31:0];
    end else if (v[50]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // configuration
  logic signed [31:0]       gain_q [3];
  logic [cai_pkg::DT_W-1:0] dt_q;
  logic                     cfg_we;
  logic [1:0]               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= '0;
      gain_q[1] <= '0;
      gain_q[2] <= '0;
      dt_q      <= cai_pkg::DT_W'(cai_pkg::DT_RESET);
    end else if (cfg_we) begin
      unique case (cai_pkg::reg_e'(cfg_idx))
        cai_pkg::REG_GAIN_X:    gain_q[0] <= pwdata;
        cai_pkg::REG_GAIN_Y:    gain_q[1] <= pwdata;
        cai_pkg::REG_GAIN_Z:    gain_q[2] <= pwdata;
        cai_pkg::REG_TIME_STEP: dt_q      <= pwdata[cai_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cai_pkg::reg_e'(cfg_idx))
      cai_pkg::REG_GAIN_X:    prdata = gain_q[0];
      cai_pkg::REG_GAIN_Y:    prdata = gain_q[1];
      cai_pkg::REG_GAIN_Z:    prdata = gain_q[2];
      cai_pkg::REG_TIME_STEP: prdata = {{(32-cai_pkg::DT_W){1'b0}}, dt_q};
      default:                prdata = '0;
    endcase
  end

  // control and state
  logic [3:0]         state_q, state_d;
  cai_pkg::in_item_t  item_q;
  logic               step_q;
  logic               have_q;
  logic               init_q;
  logic signed [31:0] pos_q [cai_pkg::AXES];
  logic signed [31:0] vel_q [cai_pkg::AXES];

  logic               in_fire;
  logic               in_have;
  logic               out_free;
  logic signed [31:0] pos_cur, vel_cur;
  logic signed [32:0] diff;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_have    = in_data_i.axis < 2'(cai_pkg::AXES);
  assign out_free   = !out_valid_o || out_ready_i;
  assign pos_cur    = pos_q[item_q.axis];
  assign vel_cur    = vel_q[item_q.axis];
  assign diff       = 33'(in_data_i.zmp_meas) - 33'(in_data_i.zmp_target);

  // digit-serial multiplier, MSB digit first
  logic signed [47:0]      a_q, a_d;
  logic [31:0]             b_q, b_d;
  logic                    bsgn_q, bsgn_d;
  logic                    first_q, first_d;
  logic [3:0]              cnt_q, cnt_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [4:0]       dig;
  logic signed [52:0]      pp;
  logic signed [ACC_W-1:0] mac;
  logic signed [ACC_W-1:0] rnd_g, rnd_dt, rnd_dt2;

  assign dig = {(first_q && bsgn_q) ? b_q[31] : 1'b0, b_q[31:28]};
  assign pp  = a_q * dig;
  assign mac = (acc_q <<< 4) + ACC_W'(pp);

  assign rnd_g   = (acc_q + (ACC_W'(1) <<< (cai_pkg::FRAC_BITS - 1)))
                   >>> cai_pkg::FRAC_BITS;
  assign rnd_dt  = (acc_q + (ACC_W'(1) <<< (cai_pkg::DT_FRAC - 1)))
                   >>> cai_pkg::DT_FRAC;
  assign rnd_dt2 = (acc_q + (ACC_W'(1) <<< (2 * cai_pkg::DT_FRAC)))
                   >>> (2 * cai_pkg::DT_FRAC + 1);

  // datapath registers
  logic signed [T_W-1:0] t_q, t_d;
  logic signed [31:0]    accel_q, accel_d;
  logic signed [33:0]    vdt_q, vdt_d, adt_q, adt_d, a2_q, a2_d;
  logic signed [31:0]    np_q, np_d, nv_q, nv_d;
  logic signed [50:0]    accel_sum;
  logic signed [35:0]    np_sum, nv_sum;

  assign accel_sum = 51'(item_q.accel_target) + 51'(t_q);
  assign np_sum    = 36'(pos_cur) + 36'(vdt_q) + 36'(a2_q);
  assign nv_sum    = 36'(vel_cur) + 36'(adt_q);

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    bsgn_d  = bsgn_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    t_d     = t_q;
    accel_d = accel_q;
    vdt_d   = vdt_q;
    adt_d   = adt_q;
    a2_d    = a2_q;
    np_d    = np_q;
    nv_d    = nv_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.op == cai_pkg::OP_STEP && in_have && init_q) begin
            a_d     = 48'(diff);
            b_d     = gain_q[in_data_i.axis];
            bsgn_d  = 1'b1;
            first_d = 1'b1;
            cnt_d   = 4'd8;
            acc_d   = '0;
            state_d = S_G_MUL;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_G_MUL, S_V_MUL, S_A_MUL, S_A2_MUL: begin
        acc_d   = mac;
        b_d     = b_q << 4;
        first_d = 1'b0;
        cnt_d   = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = state_q + 4'd1;
        end
      end
      S_G_RND: begin
        t_d     = rnd_g[T_W-1:0];
        state_d = S_ACCEL;
      end
      S_ACCEL: begin
        accel_d = sat32(accel_sum);
        a_d     = 48'(vel_cur);
        b_d     = {dt_q, 16'h0};
        bsgn_d  = 1'b0;
        first_d = 1'b1;
        cnt_d   = 4'd4;
        acc_d   = '0;
        state_d = S_V_MUL;
      end
      S_V_RND: begin
        vdt_d   = rnd_dt[33:0];
        a_d     = 48'(accel_q);
        b_d     = {dt_q, 16'h0};
        first_d = 1'b1;
        cnt_d   = 4'd4;
        acc_d   = '0;
        state_d = S_A_MUL;
      end
      S_A_RND: begin
        adt_d   = rnd_dt[33:0];
        a_d     = acc_q[47:0];
        b_d     = {dt_q, 16'h0};
        first_d = 1'b1;
        cnt_d   = 4'd4;
        acc_d   = '0;
        state_d = S_A2_MUL;
      end
      S_A2_RND: begin
        a2_d    = rnd_dt2[33:0];
        state_d = S_SUM;
      end
      S_SUM: begin
        np_d    = sat32(51'(np_sum));
        nv_d    = sat32(51'(nv_sum));
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    bsgn_q  <= bsgn_d;
    first_q <= first_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    t_q     <= t_d;
    accel_q <= accel_d;
    vdt_q   <= vdt_d;
    adt_q   <= adt_d;
    a2_q    <= a2_d;
    np_q    <= np_d;
    nv_q    <= nv_d;
    if (in_fire) begin
      item_q <= in_data_i;
      have_q <= in_have;
      step_q <= in_data_i.op == cai_pkg::OP_STEP && in_have && init_q;
    end
  end

  // axis state and output register
  logic               out_valid_q;
  cai_pkg::out_item_t out_q;
  logic               commit;

  assign commit      = (state_q == S_OUT) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
      for (int i = 0; i < int'(cai_pkg::AXES); i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else if (commit) begin
      if (item_q.op == cai_pkg::OP_INIT) begin
        init_q <= 1'b1;
        for (int i = 0; i < int'(cai_pkg::AXES); i++) begin
          pos_q[i] <= '0;
          vel_q[i] <= '0;
        end
      end else if (have_q && item_q.op == cai_pkg::OP_SET_POS) begin
        pos_q[item_q.axis] <= item_q.load_value;
      end else if (have_q && item_q.op == cai_pkg::OP_SET_VEL) begin
        vel_q[item_q.axis] <= item_q.load_value;
      end else if (step_q) begin
        pos_q[item_q.axis] <= np_q;
        vel_q[item_q.axis] <= nv_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.out_axis  <= item_q.axis;
      out_q.valid_res <= step_q;
      out_q.accel_ref <= step_q ? accel_q : '0;
      if (!have_q || item_q.op == cai_pkg::OP_INIT) begin
        out_q.pos_ref <= '0;
        out_q.vel_ref <= '0;
      end else if (item_q.op == cai_pkg::OP_SET_POS) begin
        out_q.pos_ref <= item_q.load_value;
        out_q.vel_ref <= vel_cur;
      end else if (item_q.op == cai_pkg::OP_SET_VEL) begin
        out_q.pos_ref <= pos_cur;
        out_q.vel_ref <= item_q.load_value;
      end else if (step_q) begin
        out_q.pos_ref <= np_q;
        out_q.vel_ref <= nv_q;
      end else begin
        out_q.pos_ref <= pos_cur;
        out_q.vel_ref <= vel_cur;
      end
    end
  end

endmodule

/* verif/com_admittance_integrator_top_test.sv */
`timescale 1ns / 100ps
// Testbench for com_admittance_integrator_top: queue-fed driver, randomized back-pressure,
// APB register phases and a per-item predictor of the admittance integrator.
// Depends on cai_pkg and the com_admittance_integrator_top RTL.
module com_admittance_integrator_top_test;

  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned HOLD_CYCLES = 220;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] SAT_LO = -96'sh8000_0000;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  cai_pkg::in_item_t           in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  cai_pkg::out_item_t          out_data_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [cai_pkg::PADDR_W-1:0] paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  com_admittance_integrator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] adm_gain [3] = '{default: '0};
  logic [15:0]        dt_q16 = 16'(cai_pkg::DT_RESET);
  logic signed [31:0] com_pos [cai_pkg::AXES] = '{default: '0};
  logic signed [31:0] com_vel [cai_pkg::AXES] = '{default: '0};
  logic               com_ready = 1'b0;

  cai_pkg::in_item_t  queued_items [$];
  cai_pkg::out_item_t expected_refs [$];
  int        mismatches   = 0;
  int        stall_cycles = 0;
  logic      quiet        = 1'b0;
  logic      hold_go      = 1'b0;
  logic      hold_used    = 1'b0;
  int        hold_left    = 0;

  function automatic logic signed [95:0] round_half_up(logic signed [95:0] v, int s);
    logic signed [95:0] one;
    one = 1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [95:0] v);
    if (v > SAT_HI) return 32'sh7FFF_FFFF;
    if (v < SAT_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic cai_pkg::out_item_t advance_com_model(cai_pkg::in_item_t it);
    cai_pkg::out_item_t r;
    int                 ax;
    logic               have_axis;
    logic signed [95:0] diff, gain_w, dt_w, acc_w, vold, np, nv;
    logic signed [31:0] acc;
    r = '0;
    r.out_axis = it.axis;
    ax = int'(it.axis);
    have_axis = ax < cai_pkg::AXES;
    case (it.op)
      cai_pkg::OP_INIT: begin
        for (int k = 0; k < cai_pkg::AXES; k++) begin
          com_pos[k] = '0;
          com_vel[k] = '0;
        end
        com_ready = 1'b1;
      end
      cai_pkg::OP_SET_POS: if (have_axis) com_pos[ax] = it.load_value;
      cai_pkg::OP_SET_VEL: if (have_axis) com_vel[ax] = it.load_value;
      cai_pkg::OP_STEP: begin
        if (have_axis && com_ready) begin
          diff   = 96'($signed(it.zmp_meas)) - 96'($signed(it.zmp_target));
          gain_w = 96'($signed(adm_gain[ax]));
          dt_w   = dt_q16;
          acc    = clamp32(96'($signed(it.accel_target))
                           + round_half_up(gain_w * diff, cai_pkg::FRAC_BITS));
          acc_w  = 96'(acc);
          vold   = 96'(com_vel[ax]);
          np     = 96'(com_pos[ax]) + round_half_up(vold * dt_w, cai_pkg::DT_FRAC)
                   + round_half_up(acc_w * dt_w * dt_w, 2 * cai_pkg::DT_FRAC + 1);
          nv     = vold + round_half_up(acc_w * dt_w, cai_pkg::DT_FRAC);
          com_pos[ax] = clamp32(np);
          com_vel[ax] = clamp32(nv);
          r.valid_res = 1'b1;
          r.accel_ref = acc;
        end
      end
      default: ;
    endcase
    if (have_axis) begin
      r.pos_ref = com_pos[ax];
      r.vel_ref = com_vel[ax];
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (queued_items.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= queued_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_refs.push_back(advance_com_model(in_data_i));
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_used   <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cai_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_refs.size() == 0) begin
        $error("unexpected result beat: out_axis %0d", out_data_o.out_axis);
        mismatches++;
      end else begin
        exp_r = expected_refs.pop_front();
        if (out_data_o.out_axis !== exp_r.out_axis) begin
          $error("out_axis: expected %0d, got %0d", exp_r.out_axis, out_data_o.out_axis);
          mismatches++;
        end
        if (out_data_o.valid_res !== exp_r.valid_res) begin
          $error("valid_res: expected %0d, got %0d", exp_r.valid_res, out_data_o.valid_res);
          mismatches++;
        end
        if (out_data_o.accel_ref !== exp_r.accel_ref) begin
          $error("accel_ref: expected %0d, got %0d", exp_r.accel_ref, out_data_o.accel_ref);
          mismatches++;
        end
        if (out_data_o.pos_ref !== exp_r.pos_ref) begin
          $error("pos_ref: expected %0d, got %0d", exp_r.pos_ref, out_data_o.pos_ref);
          mismatches++;
        end
        if (out_data_o.vel_ref !== exp_r.vel_ref) begin
          $error("vel_ref: expected %0d, got %0d", exp_r.vel_ref, out_data_o.vel_ref);
          mismatches++;
        end
      end
    end
  end

  // cycles without any accepted beat or APB access
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  task automatic reg_write(cai_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == cai_pkg::REG_TIME_STEP) dt_q16 = val[15:0];
    else adm_gain[idx] = val;
  endtask

  task automatic load_config(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                             logic [31:0] dt);
    reg_write(cai_pkg::REG_GAIN_X, gx);
    reg_write(cai_pkg::REG_GAIN_Y, gy);
    reg_write(cai_pkg::REG_GAIN_Z, gz);
    reg_write(cai_pkg::REG_TIME_STEP, dt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (queued_items.size() != 0 || in_valid_i || expected_refs.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_item(cai_pkg::op_e op, logic [1:0] axis, logic [31:0] meas,
                           logic [31:0] tgt, logic [31:0] acc, logic [31:0] load);
    cai_pkg::in_item_t it;
    it.op           = op;
    it.axis         = axis;
    it.zmp_meas     = meas;
    it.zmp_target   = tgt;
    it.accel_target = acc;
    it.load_value   = load;
    queued_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    return $urandom_range(0, 3) == 0 ? $urandom()
                                     : 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  task automatic push_random();
    int           sel;
    cai_pkg::op_e op;
    logic [1:0]   axis;
    logic [31:0]  tgt;
    sel  = $urandom_range(0, 99);
    op   = sel < 70 ? cai_pkg::OP_STEP : sel < 82 ? cai_pkg::OP_SET_POS :
           sel < 94 ? cai_pkg::OP_SET_VEL : cai_pkg::OP_INIT;
    axis = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    tgt  = pick_value();
    push_item(op, axis,
              $urandom_range(0, 2) == 0 ? pick_value()
                                        : tgt + 32'($urandom_range(0, 8191)) - 32'd4096,
              tgt, pick_value(), pick_value());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: not initialized, sets act anyway, missing axis
    push_item(cai_pkg::OP_STEP,    2'd0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0);
    push_item(cai_pkg::OP_SET_POS, 2'd1, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    push_item(cai_pkg::OP_SET_VEL, 2'd2, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    push_item(cai_pkg::OP_STEP,    2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    push_item(cai_pkg::OP_STEP,    2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    push_item(cai_pkg::OP_INIT,    2'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_item(cai_pkg::OP_STEP,    2'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_item(cai_pkg::OP_SET_POS, 2'd3, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
    push_item(cai_pkg::OP_SET_VEL, 2'd3, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
    push_item(cai_pkg::OP_STEP,    2'd0, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    drain();

    // extreme gains and time step
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_FFFF);
    push_item(cai_pkg::OP_INIT,    2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_item(cai_pkg::OP_STEP,    2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    push_item(cai_pkg::OP_STEP,    2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0);
    push_item(cai_pkg::OP_SET_VEL, 2'd2, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    push_item(cai_pkg::OP_STEP,    2'd2, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    push_item(cai_pkg::OP_SET_POS, 2'd2, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    push_item(cai_pkg::OP_SET_VEL, 2'd2, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    push_item(cai_pkg::OP_STEP,    2'd2, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
    push_item(cai_pkg::OP_STEP,    2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_item(cai_pkg::OP_SET_POS, 2'd0, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
    push_item(cai_pkg::OP_STEP,    2'd0, 32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0);
    push_item(cai_pkg::OP_STEP,    2'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(pick_gain(), pick_gain(), pick_gain(), cai_pkg::DT_RESET);
        1: load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        2: load_config($urandom(), $urandom(), $urandom(), 32'h0000_FFFF);
        default: load_config(pick_gain(), pick_gain(), pick_gain(),
                             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000));
      endcase
      quiet = (ph == 3);
      push_item(cai_pkg::OP_INIT, 2'($urandom_range(0, 3)), $urandom(), $urandom(),
                $urandom(), $urandom());
      if (ph == 2) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) push_random();
      drain();
    end
    quiet = 1'b0;

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_refs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/cai_pkg.sv
rtl/core/com_admittance_integrator_top.sv
verif/com_admittance_integrator_top_test.sv
